[rtl/core/crbz_pkg.sv]
// Shared widths, types and arithmetic helpers for the cubic-to-quadratic core.
// Used by crbz_div, crbz_half and cubic_bezier_to_two_quadratics_core.
package crbz_pkg;

  localparam int CW     = 24;          // coordinate width, signed Q15.8
  localparam int DW     = CW + 1;      // difference of two coordinates
  localparam int PW     = 2 * DW;      // product of two differences
  localparam int WW     = PW + 1;      // cross product (det, ray numerators)
  localparam int MW     = WW;          // magnitude of a cross product
  localparam int LOW_W  = (MW + 1) / 2;
  localparam int HIGH_W = MW - LOW_W;
  localparam int NW     = MW + DW;     // dividend: numerator times direction
  localparam int QB     = CW + 3;      // quotient bits kept by the divider
  localparam int SW     = CW + 5;      // start plus offset before saturation

  localparam int DIV_LAT  = QB + 1;       // divider register stages
  localparam int HALF_LAT = DIV_LAT + 5;  // half unit: 4 front + divider + output
  localparam int FRONT    = 3;            // split stages ahead of the half units
  localparam int LAT      = FRONT + HALF_LAT;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [DW-1:0] diff_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [WW-1:0] wide_t;
  typedef logic signed [SW-1:0] sum_t;
  typedef logic        [MW-1:0] mag_t;
  typedef logic        [DW-1:0] dmag_t;
  typedef logic        [NW-1:0] num_t;
  typedef logic        [QB-1:0] quot_t;

  // Largest offset kept; anything beyond saturates anyway.
  localparam quot_t LIM = quot_t'(1) << (CW + 2);

  // Data that rides alongside the divider.
  typedef struct packed {
    coord_t as_x;
    coord_t as_y;
    coord_t mid_x;
    coord_t mid_y;
    logic   neg_x;
    logic   neg_y;
    logic   fb;
  } side_t;

  // Floor of the average of two coordinates.
  function automatic coord_t half_floor(coord_t a, coord_t b);
    logic signed [CW:0] s;
    s = (CW + 1)'(a) + (CW + 1)'(b);
    return s[CW:1];
  endfunction

  // Clamp to the signed coordinate range.
  function automatic coord_t sat(sum_t v);
    sum_t hi;
    sum_t lo;
    hi = sum_t'({1'b0, {(CW-1){1'b1}}});
    lo = -hi - sum_t'(1);
    if (v > hi) return coord_t'({1'b0, {(CW-1){1'b1}}});
    if (v < lo) return coord_t'({1'b1, {(CW-1){1'b0}}});
    return v[CW-1:0];
  endfunction

endpackage

[rtl/core/cubic_bezier_to_two_quadratics_core.sv]
// Top level: splits a cubic Bezier at t = 1/2 into two quadratics.
// Depends on crbz_pkg and crbz_half (which uses crbz_div).
//
// Usage:
//   Input channel (in_valid / in_stall) carries one cubic per transfer:
//   start, two controls and end, each a signed Q15.8 x/y pair.
//   Output channel (out_valid / out_stall) carries the split point, the two
//   quadratic control points and a fallback flag per half.
// Stages: from input transfer to out_valid a curve passes through
//   3 de Casteljau stages, 4 cross-product/multiply stages, a 28-stage
//   divider pipeline and one output register.
// Throughput: one curve per cycle unless a held result stalls the pipeline;
//   every stage, including the divider, takes a new item each cycle.
// Reset (rst, synchronous) empties the pipeline: all valid bits clear and
//   out_valid drops; no state survives between curves.
// Stall: while out_valid is high and out_stall is high the whole pipeline
//   holds, the output stays unchanged and in_stall rises; nothing is lost or
//   repeated. When no result is held, the pipeline advances and takes input.
module cubic_bezier_to_two_quadratics_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  crbz_pkg::coord_t start_x,
  input  crbz_pkg::coord_t start_y,
  input  crbz_pkg::coord_t ctrl1_x,
  input  crbz_pkg::coord_t ctrl1_y,
  input  crbz_pkg::coord_t ctrl2_x,
  input  crbz_pkg::coord_t ctrl2_y,
  input  crbz_pkg::coord_t end_x,
  input  crbz_pkg::coord_t end_y,
  output logic             out_valid,
  input  logic             out_stall,
  output crbz_pkg::coord_t first_ctrl_x,
  output crbz_pkg::coord_t first_ctrl_y,
  output crbz_pkg::coord_t split_x,
  output crbz_pkg::coord_t split_y,
  output crbz_pkg::coord_t second_ctrl_x,
  output crbz_pkg::coord_t second_ctrl_y,
  output logic             first_fallback,
  output logic             second_fallback
);
  import crbz_pkg::*;

  logic en;
  logic vld [LAT];

  // Advance unless a finished result is held
  assign en       = !(vld[LAT-1] && out_stall);
  assign in_stall = !en;
  assign out_valid = vld[LAT-1];

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAT; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int i = 1; i < LAT; i++) vld[i] <= vld[i-1];
    end
  end

  // Stage 1: first midpoints and end directions
  coord_t p0_1 [2], p3_1 [2], m0_1 [2], m1_1 [2], m2_1 [2];
  diff_t  a1_1 [2], a2_1 [2];
  coord_t p0_i [2], p1_i [2], p2_i [2], p3_i [2];

  always_comb begin
    p0_i[0] = start_x;  p0_i[1] = start_y;
    p1_i[0] = ctrl1_x;  p1_i[1] = ctrl1_y;
    p2_i[0] = ctrl2_x;  p2_i[1] = ctrl2_y;
    p3_i[0] = end_x;    p3_i[1] = end_y;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 2; k++) begin
        p0_1[k] <= p0_i[k];
        p3_1[k] <= p3_i[k];
        m0_1[k] <= half_floor(p0_i[k], p1_i[k]);
        m1_1[k] <= half_floor(p1_i[k], p2_i[k]);
        m2_1[k] <= half_floor(p2_i[k], p3_i[k]);
        a1_1[k] <= diff_t'(p1_i[k]) - diff_t'(p0_i[k]);
        a2_1[k] <= diff_t'(p2_i[k]) - diff_t'(p3_i[k]);
      end
    end
  end

  // Stage 2: tangent points at the split
  coord_t p0_2 [2], p3_2 [2], t0_2 [2], t1_2 [2];
  diff_t  a1_2 [2], a2_2 [2];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 2; k++) begin
        p0_2[k] <= p0_1[k];
        p3_2[k] <= p3_1[k];
        t0_2[k] <= half_floor(m0_1[k], m1_1[k]);
        t1_2[k] <= half_floor(m1_1[k], m2_1[k]);
        a1_2[k] <= a1_1[k];
        a2_2[k] <= a2_1[k];
      end
    end
  end

  // Stage 3: split point and ray/line differences for both halves
  coord_t p0_3 [2], p3_3 [2], s_3 [2];
  diff_t  a1_3 [2], a2_3 [2], d1_3 [2], d2_3 [2], b1_3 [2], b2_3 [2];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 2; k++) begin
        p0_3[k] <= p0_2[k];
        p3_3[k] <= p3_2[k];
        s_3[k]  <= half_floor(t0_2[k], t1_2[k]);
        a1_3[k] <= a1_2[k];
        a2_3[k] <= a2_2[k];
        d1_3[k] <= diff_t'(t1_2[k]) - diff_t'(p0_2[k]);
        d2_3[k] <= diff_t'(t0_2[k]) - diff_t'(p3_2[k]);
        b1_3[k] <= diff_t'(t0_2[k]) - diff_t'(t1_2[k]);
        b2_3[k] <= diff_t'(t1_2[k]) - diff_t'(t0_2[k]);
      end
    end
  end

  // Half units
  crbz_half u_first (
    .clk(clk), .en(en),
    .as_x(p0_3[0]), .as_y(p0_3[1]), .s_x(s_3[0]), .s_y(s_3[1]),
    .ax(a1_3[0]), .ay(a1_3[1]), .dx(d1_3[0]), .dy(d1_3[1]),
    .bx(b1_3[0]), .by(b1_3[1]),
    .ctrl_x(first_ctrl_x), .ctrl_y(first_ctrl_y), .fallback(first_fallback)
  );

  crbz_half u_second (
    .clk(clk), .en(en),
    .as_x(p3_3[0]), .as_y(p3_3[1]), .s_x(s_3[0]), .s_y(s_3[1]),
    .ax(a2_3[0]), .ay(a2_3[1]), .dx(d2_3[0]), .dy(d2_3[1]),
    .bx(b2_3[0]), .by(b2_3[1]),
    .ctrl_x(second_ctrl_x), .ctrl_y(second_ctrl_y), .fallback(second_fallback)
  );

  // Delay the split point to line up with the half units
  coord_t sdl_x [HALF_LAT], sdl_y [HALF_LAT];
  always_ff @(posedge clk) begin
    if (en) begin
      sdl_x[0] <= s_3[0];
      sdl_y[0] <= s_3[1];
      for (int i = 1; i < HALF_LAT; i++) begin
        sdl_x[i] <= sdl_x[i-1];
        sdl_y[i] <= sdl_y[i-1];
      end
    end
  end

  assign split_x = sdl_x[HALF_LAT-1];
  assign split_y = sdl_y[HALF_LAT-1];

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high right after reset");

  // A held result is neither dropped nor altered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    $past(!rst && out_valid && out_stall) |->
      out_valid && $stable(split_x) && $stable(first_ctrl_x) && $stable(second_ctrl_y))
    else $error("held result changed or dropped");

  // Pipeline freezes while input is stalled
  a_freeze: assert property (@(posedge clk) disable iff (rst)
    $past(!rst && in_stall) |-> $stable(vld[0]) && $stable(vld[LAT-2]))
    else $error("pipeline moved during stall");

endmodule

[rtl/core/crbz_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// Depends on crbz_pkg for widths.
module crbz_div (
  input  logic             clk,
  input  logic             en,
  input  crbz_pkg::num_t   num,
  input  crbz_pkg::mag_t   den,
  output crbz_pkg::quot_t  quot,
  output logic             ovf
);
  import crbz_pkg::*;

  mag_t  rem_q [QB+1];
  quot_t low_q [QB+1];
  quot_t q_q   [QB+1];
  mag_t  den_q [QB+1];
  logic  ovf_q [QB+1];

  // Load stage: quotient too large for QB bits is flagged here
  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0] <= mag_t'(num[NW-1:QB]);
      low_q[0] <= num[QB-1:0];
      q_q[0]   <= '0;
      den_q[0] <= den;
      ovf_q[0] <= (mag_t'(num[NW-1:QB]) >= den);
    end
  end

  // One trial subtraction per stage
  for (genvar i = 1; i <= QB; i++) begin : g_stage
    logic [MW:0] trial;
    logic        take;
    always_comb begin
      trial = {rem_q[i-1], low_q[i-1][QB-1]};
      take  = (trial >= {1'b0, den_q[i-1]});
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[i] <= take ? mag_t'(trial - {1'b0, den_q[i-1]}) : trial[MW-1:0];
        low_q[i] <= low_q[i-1] << 1;
        q_q[i]   <= {q_q[i-1][QB-2:0], take};
        den_q[i] <= den_q[i-1];
        ovf_q[i] <= ovf_q[i-1];
      end
    end
  end

  assign quot = q_q[QB];
  assign ovf  = ovf_q[QB];

endmodule

[rtl/core/crbz_half.sv]
// One half of the split: ray/line intersection, divide, saturate, fallback.
// Depends on crbz_pkg and crbz_div.
module crbz_half (
  input  logic             clk,
  input  logic             en,
  input  crbz_pkg::coord_t as_x,
  input  crbz_pkg::coord_t as_y,
  input  crbz_pkg::coord_t s_x,
  input  crbz_pkg::coord_t s_y,
  input  crbz_pkg::diff_t  ax,
  input  crbz_pkg::diff_t  ay,
  input  crbz_pkg::diff_t  dx,
  input  crbz_pkg::diff_t  dy,
  input  crbz_pkg::diff_t  bx,
  input  crbz_pkg::diff_t  by,
  output crbz_pkg::coord_t ctrl_x,
  output crbz_pkg::coord_t ctrl_y,
  output logic             fallback
);
  import crbz_pkg::*;

  // Stage 4: cross-product terms
  prod_t  p_bxay, p_byax, p_dybx, p_dxby, p_dyax, p_dxay;
  coord_t as4_x, as4_y, mid4_x, mid4_y;
  diff_t  ax4, ay4;

  always_ff @(posedge clk) begin
    if (en) begin
      p_bxay <= bx * ay;
      p_byax <= by * ax;
      p_dybx <= dy * bx;
      p_dxby <= dx * by;
      p_dyax <= dy * ax;
      p_dxay <= dx * ay;
      as4_x  <= as_x;
      as4_y  <= as_y;
      mid4_x <= half_floor(as_x, s_x);
      mid4_y <= half_floor(as_y, s_y);
      ax4    <= ax;
      ay4    <= ay;
    end
  end

  // Stage 5: determinant, ray tests, magnitudes
  wide_t det, un, vn;
  logic  fb5_next;
  always_comb begin
    det = wide_t'(p_bxay) - wide_t'(p_byax);
    un  = wide_t'(p_dybx) - wide_t'(p_dxby);
    vn  = wide_t'(p_dyax) - wide_t'(p_dxay);
    fb5_next = (det == '0) || (un == '0) || (un[WW-1] != det[WW-1]) ||
               (vn == '0) || (vn[WW-1] != det[WW-1]);
  end

  mag_t   mu5, md5;
  dmag_t  dm5_x, dm5_y;
  side_t  sd5;
  always_ff @(posedge clk) begin
    if (en) begin
      mu5       <= un[WW-1] ? mag_t'(-un) : mag_t'(un);
      md5       <= det[WW-1] ? mag_t'(-det) : mag_t'(det);
      dm5_x     <= ax4[DW-1] ? dmag_t'(-ax4) : dmag_t'(ax4);
      dm5_y     <= ay4[DW-1] ? dmag_t'(-ay4) : dmag_t'(ay4);
      sd5.as_x  <= as4_x;
      sd5.as_y  <= as4_y;
      sd5.mid_x <= mid4_x;
      sd5.mid_y <= mid4_y;
      sd5.neg_x <= ax4[DW-1];
      sd5.neg_y <= ay4[DW-1];
      sd5.fb    <= fb5_next;
    end
  end

  // Stage 6: partial products of numerator times direction
  logic [LOW_W+DW-1:0]  pl_x, pl_y;
  logic [HIGH_W+DW-1:0] ph_x, ph_y;
  mag_t  md6;
  side_t sd6;
  always_ff @(posedge clk) begin
    if (en) begin
      pl_x <= (LOW_W+DW)'(mu5[LOW_W-1:0]) * (LOW_W+DW)'(dm5_x);
      pl_y <= (LOW_W+DW)'(mu5[LOW_W-1:0]) * (LOW_W+DW)'(dm5_y);
      ph_x <= (HIGH_W+DW)'(mu5[MW-1:LOW_W]) * (HIGH_W+DW)'(dm5_x);
      ph_y <= (HIGH_W+DW)'(mu5[MW-1:LOW_W]) * (HIGH_W+DW)'(dm5_y);
      md6  <= md5;
      sd6  <= sd5;
    end
  end

  // Stage 7: combine partial products into the dividends
  num_t  num7_x, num7_y;
  mag_t  md7;
  side_t sd7;
  always_ff @(posedge clk) begin
    if (en) begin
      num7_x <= (num_t'(ph_x) << LOW_W) + num_t'(pl_x);
      num7_y <= (num_t'(ph_y) << LOW_W) + num_t'(pl_y);
      md7    <= md6;
      sd7    <= sd6;
    end
  end

  // Dividers, with the side data delayed to match
  quot_t q_x, q_y;
  logic  ovf_x, ovf_y;

  crbz_div u_div_x (.clk(clk), .en(en), .num(num7_x), .den(md7), .quot(q_x), .ovf(ovf_x));
  crbz_div u_div_y (.clk(clk), .en(en), .num(num7_y), .den(md7), .quot(q_y), .ovf(ovf_y));

  side_t sdl [DIV_LAT];
  always_ff @(posedge clk) begin
    if (en) begin
      sdl[0] <= sd7;
      for (int i = 1; i < DIV_LAT; i++) sdl[i] <= sdl[i-1];
    end
  end

  // Output stage: clamp offset, apply sign, add to start, saturate
  quot_t  qc_x, qc_y;
  sum_t   off_x, off_y;
  coord_t pt_x, pt_y;
  side_t  sdo;
  always_comb begin
    sdo   = sdl[DIV_LAT-1];
    qc_x  = (ovf_x || q_x > LIM) ? LIM : q_x;
    qc_y  = (ovf_y || q_y > LIM) ? LIM : q_y;
    off_x = sdo.neg_x ? -sum_t'(qc_x) : sum_t'(qc_x);
    off_y = sdo.neg_y ? -sum_t'(qc_y) : sum_t'(qc_y);
    pt_x  = sat(sum_t'(sdo.as_x) + off_x);
    pt_y  = sat(sum_t'(sdo.as_y) + off_y);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctrl_x   <= sdo.fb ? sdo.mid_x : pt_x;
      ctrl_y   <= sdo.fb ? sdo.mid_y : pt_y;
      fallback <= sdo.fb;
    end
  end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for cubic_bezier_to_two_quadratics_core: directed table, random curves.
// Depends on crbz_pkg and the core RTL; predicts each split and both controls in wide integers.
module tb_top;
  import crbz_pkg::*;

  localparam int NUM_RANDOM = 950;
  localparam int DRAIN_CYCLES = 80;
  localparam int MAX_REPORTS = 10;
  localparam longint CMIN = -(64'sd1 <<< (CW - 1));
  localparam longint CMAX = (64'sd1 <<< (CW - 1)) - 1;

  typedef struct {
    coord_t c1x, c1y, sx, sy, c2x, c2y;
    logic f1, f2;
  } quad_pair_t;

  typedef struct {
    coord_t p[8];
    logic has_exp;
    quad_pair_t exp_res;
  } curve_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  coord_t start_x = '0, start_y = '0, ctrl1_x = '0, ctrl1_y = '0;
  coord_t ctrl2_x = '0, ctrl2_y = '0, end_x = '0, end_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  coord_t first_ctrl_x, first_ctrl_y, split_x, split_y, second_ctrl_x, second_ctrl_y;
  logic first_fallback, second_fallback;

  quad_pair_t pending_quads[$];
  int mismatch_count = 0;
  logic stim_done = 1'b0;

  cubic_bezier_to_two_quadratics_core u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Floor of the average, exact on wide integers
  function automatic longint avg_floor(longint a, longint b);
    return (a + b) >>> 1;
  endfunction

  function automatic longint clamp_coord(longint v);
    if (v < CMIN) return CMIN;
    if (v > CMAX) return CMAX;
    return v;
  endfunction

  // Ray from as toward ad meets line from bs toward bd strictly forward
  function automatic logic meet_ray(longint asx, longint asy, longint adx, longint ady,
                                    longint bsx, longint bsy, longint bdx, longint bdy,
                                    output longint ox, output longint oy);
    longint dx, dy, ax, ay, bx, by;
    logic signed [127:0] det, un, vn, q;
    dx = bsx - asx; dy = bsy - asy;
    ax = adx - asx; ay = ady - asy;
    bx = bdx - bsx; by = bdy - bsy;
    det = 128'(bx) * 128'(ay) - 128'(by) * 128'(ax);
    if (det == 0) return 1'b0;
    un = 128'(dy) * 128'(bx) - 128'(dx) * 128'(by);
    vn = 128'(dy) * 128'(ax) - 128'(dx) * 128'(ay);
    if (un == 0 || (un < 0) != (det < 0)) return 1'b0;
    if (vn == 0 || (vn < 0) != (det < 0)) return 1'b0;
    // Signed division truncates toward zero; clamp magnitude like the offset limit
    q = (un * 128'(ax)) / det;
    if (q > (128'sd1 <<< (CW + 2))) q = 128'sd1 <<< (CW + 2);
    if (q < -(128'sd1 <<< (CW + 2))) q = -(128'sd1 <<< (CW + 2));
    ox = clamp_coord(asx + longint'(q));
    q = (un * 128'(ay)) / det;
    if (q > (128'sd1 <<< (CW + 2))) q = 128'sd1 <<< (CW + 2);
    if (q < -(128'sd1 <<< (CW + 2))) q = -(128'sd1 <<< (CW + 2));
    oy = clamp_coord(asy + longint'(q));
    return 1'b1;
  endfunction

  function automatic quad_pair_t predict_quads(coord_t p[8]);
    quad_pair_t r;
    longint v[8], m0[2], m1[2], m2[2], t0[2], t1[2], s[2], cx, cy;
    for (int i = 0; i < 8; i++) v[i] = longint'(p[i]);
    for (int k = 0; k < 2; k++) begin
      m0[k] = avg_floor(v[k], v[2 + k]);
      m1[k] = avg_floor(v[2 + k], v[4 + k]);
      m2[k] = avg_floor(v[4 + k], v[6 + k]);
      t0[k] = avg_floor(m0[k], m1[k]);
      t1[k] = avg_floor(m1[k], m2[k]);
      s[k] = avg_floor(t0[k], t1[k]);
    end
    r.sx = coord_t'(s[0]);
    r.sy = coord_t'(s[1]);
    r.f1 = !meet_ray(v[0], v[1], v[2], v[3], t1[0], t1[1], t0[0], t0[1], cx, cy);
    if (r.f1) begin
      cx = avg_floor(v[0], s[0]);
      cy = avg_floor(v[1], s[1]);
    end
    r.c1x = coord_t'(cx);
    r.c1y = coord_t'(cy);
    r.f2 = !meet_ray(v[6], v[7], v[4], v[5], t0[0], t0[1], t1[0], t1[1], cx, cy);
    if (r.f2) begin
      cx = avg_floor(s[0], v[6]);
      cy = avg_floor(s[1], v[7]);
    end
    r.c2x = coord_t'(cx);
    r.c2y = coord_t'(cy);
    return r;
  endfunction

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(0, 4095)) - coord_t'(2048);
      2: return $urandom_range(0, 1) ? coord_t'(CMAX) : coord_t'(CMIN);
      default: return coord_t'($urandom_range(0, 255)) - coord_t'(128);
    endcase
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 3) != 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // Present one curve and hold it until the transfer happens
  task automatic send_curve(coord_t p[8]);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    pending_quads = {pending_quads, predict_quads(p)};
    in_valid <= 1'b1;
    start_x <= p[0]; start_y <= p[1];
    ctrl1_x <= p[2]; ctrl1_y <= p[3];
    ctrl2_x <= p[4]; ctrl2_y <= p[5];
    end_x <= p[6]; end_y <= p[7];
    do @(posedge clk); while (in_stall);
  endtask

  // Randomly stall the result channel in bursts
  initial begin
    int g;
    @(negedge rst);
    forever begin
      g = gap_len();
      if (g > 0) begin
        out_stall <= 1'b1;
        repeat (g) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    quad_pair_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_quads.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) $display("unexpected result transfer at %0t", $time);
      end else begin
        e = pending_quads.pop_front();
        if (e.c1x !== first_ctrl_x || e.c1y !== first_ctrl_y || e.sx !== split_x ||
            e.sy !== split_y || e.c2x !== second_ctrl_x || e.c2y !== second_ctrl_y ||
            e.f1 !== first_fallback || e.f2 !== second_fallback) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display({"mismatch at %0t: exp c1=(%0d,%0d) s=(%0d,%0d) c2=(%0d,%0d) fb=%b%b",
                      " got c1=(%0d,%0d) s=(%0d,%0d) c2=(%0d,%0d) fb=%b%b"},
                     $time, e.c1x, e.c1y, e.sx, e.sy, e.c2x, e.c2y, e.f1, e.f2,
                     first_ctrl_x, first_ctrl_y, split_x, split_y, second_ctrl_x,
                     second_ctrl_y, first_fallback, second_fallback);
        end
      end
    end
  end

  // Stimulus: directed table, then random curves
  initial begin
    curve_row_t dir_rows[$];
    curve_row_t row;
    coord_t p[8];
    int mode;
    // All zero: every ray is degenerate, both halves fall back
    row.p = '{default: '0};
    row.has_exp = 1'b1;
    row.exp_res = '{0, 0, 0, 0, 0, 0, 1'b1, 1'b1};
    dir_rows = {dir_rows, row};
    row.has_exp = 1'b0;
    // Extremes of every field
    row.p = '{default: coord_t'(CMAX)}; dir_rows = {dir_rows, row};
    row.p = '{default: coord_t'(CMIN)}; dir_rows = {dir_rows, row};
    row.p = '{coord_t'(CMIN), coord_t'(CMIN), coord_t'(CMAX), coord_t'(CMIN),
              coord_t'(CMAX), coord_t'(CMAX), coord_t'(CMIN), coord_t'(CMAX)};
    dir_rows = {dir_rows, row};
    row.p = '{coord_t'(CMAX), coord_t'(CMIN), coord_t'(CMIN), coord_t'(CMAX),
              coord_t'(CMAX), coord_t'(CMAX), coord_t'(CMIN), coord_t'(CMIN)};
    dir_rows = {dir_rows, row};
    // Straight line: parallel rays
    row.p = '{0, 0, 256, 0, 512, 0, 768, 0}; dir_rows = {dir_rows, row};
    // Ordinary arch: forward meeting on both halves
    row.p = '{0, 0, 0, 2560, 2560, 2560, 2560, 0}; dir_rows = {dir_rows, row};
    // Looped curve with crossed controls: forward meeting on both halves
    row.p = '{0, 0, 2560, 2560, -2560, 2560, 0, 0}; dir_rows = {dir_rows, row};
    // Near-limit coordinates with short end tangents
    row.p = '{-8000000, 0, -7999999, 1, 7999999, 3, 8000000, 0};
    dir_rows = {dir_rows, row};
    row.p = '{0, -8000000, 1, -7999999, 5, 7999999, 0, 8000000};
    dir_rows = {dir_rows, row};
    // Coincident control and endpoint
    row.p = '{100, 100, 100, 100, 900, 300, 1200, -50}; dir_rows = {dir_rows, row};
    row.p = '{-7, -3, -1, 5, 9, -11, 13, 13}; dir_rows = {dir_rows, row};

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dir_rows[i]) begin
      send_curve(dir_rows[i].p);
      if (dir_rows[i].has_exp) pending_quads[$] = dir_rows[i].exp_res;
    end
    for (int n = 0; n < NUM_RANDOM; n++) begin
      mode = $urandom_range(0, 3);
      for (int j = 0; j < 8; j++) p[j] = rand_coord($urandom_range(0, 5) == 0 ? 0 : mode);
      send_curve(p);
    end
    in_valid <= 1'b0;
    stim_done <= 1'b1;
  end

  // Drain and report
  initial begin
    @(posedge stim_done);
    while (pending_quads.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  // Run limit
  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

[cubic_bezier_to_two_quadratics_core.f]
rtl/core/crbz_pkg.sv
rtl/core/crbz_div.sv
rtl/core/crbz_half.sv
rtl/core/cubic_bezier_to_two_quadratics_core.sv
bench/tb_top.sv
